>>> src/rgf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgf_pkg: shared definitions for the radial growth force pipeline
// Default widths and configuration register indexes.
// ----------------------------------------------------------------------------
package rgf_pkg;

	// Default value format: signed Q16.16.
	localparam int VALUE_WIDTH_DEF   = 32;
	localparam int FRACTION_BITS_DEF = 16;

	// Configuration register index width.
	localparam int CFG_IDX_W = 2;

	// Configuration register map.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GROWTH_RATE   = 2'd0,
		REG_LINEAR_MODE   = 2'd1,
		REG_BOUNDARY_ONLY = 2'd2,
		REG_ACTIVE_DIMS   = 2'd3
	} cfg_reg_t;

endpackage

>>> src/rgf_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgf_delay: stallable delay line
// Carries side data alongside the arithmetic units for a fixed stage count.
// ----------------------------------------------------------------------------
module rgf_delay
	import rgf_pkg::*;
#(
	parameter int WIDTH = VALUE_WIDTH_DEF,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_s [DEPTH];

	// Shift one stage whenever the pipeline advances.
	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= din;
			for (int k = 1; k < DEPTH; k++) begin
				tap_s[k] <= tap_s[k-1];
			end
		end
	end

	assign dout = tap_s[DEPTH-1];

endmodule

>>> src/rgf_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgf_isqrt: pipelined integer square root
// Digit recurrence, one root bit per stage; result is the floor of the root.
// ----------------------------------------------------------------------------
module rgf_isqrt
	import rgf_pkg::*;
#(
	parameter int IN_W = 2 * VALUE_WIDTH_DEF + 2,
	localparam int OUT_W = IN_W / 2
) (
	input  logic             clk,
	input  logic             en,
	input  logic [IN_W-1:0]  radicand,
	output logic [OUT_W-1:0] root
);

	logic [IN_W-1:0]  rad_s  [OUT_W];
	logic [OUT_W+1:0] rem_s  [OUT_W];
	logic [OUT_W-1:0] root_s [OUT_W];

	for (genvar k = 0; k < OUT_W; k++) begin : g_stage
		logic [IN_W-1:0]  rad_p;
		logic [OUT_W+1:0] rem_p;
		logic [OUT_W-1:0] root_p;
		logic [OUT_W+1:0] rem_sh;
		logic [OUT_W+1:0] trial;
		logic             ge;

		// The first stage starts from the incoming radicand.
		if (k == 0) begin : g_first
			assign rad_p  = radicand;
			assign rem_p  = '0;
			assign root_p = '0;
		end else begin : g_next
			assign rad_p  = rad_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
		end

		// Bring down two radicand bits and try the next root bit.
		always_comb begin
			rem_sh = {rem_p[OUT_W-1:0], rad_p[IN_W-1 -: 2]};
			trial  = {root_p, 2'b01};
			ge     = (rem_sh >= trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= rad_p << 2;
				rem_s[k]  <= ge ? (rem_sh - trial) : rem_sh;
				root_s[k] <= {root_p[OUT_W-2:0], ge};
			end
		end
	end

	assign root = root_s[OUT_W-1];

endmodule

>>> src/rgf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgf_div: pipelined restoring divider
// One quotient bit per stage. The quotient must fit QW bits, that is the
// numerator must be below divisor times 2^QW.
// ----------------------------------------------------------------------------
module rgf_div
	import rgf_pkg::*;
#(
	parameter int QW = VALUE_WIDTH_DEF,
	localparam int DW = QW + 1,
	localparam int NW = 2 * QW
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quot
);

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] low_s [QW];
	logic [DW-1:0] den_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_p;
		logic [QW-1:0] low_p;
		logic [DW-1:0] den_p;
		logic [DW:0]   sh;
		logic          ge;

		// The upper numerator half is the initial partial remainder.
		if (k == 0) begin : g_first
			assign rem_p = {1'b0, num[NW-1:QW]};
			assign low_p = num[QW-1:0];
			assign den_p = den;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign low_p = low_s[k-1];
			assign den_p = den_s[k-1];
		end

		// Shift in the next numerator bit and subtract when it fits.
		always_comb begin
			sh = {rem_p, low_p[QW-1]};
			ge = (sh >= {1'b0, den_p});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(sh - {1'b0, den_p}) : sh[DW-1:0];
				low_s[k] <= {low_p[QW-2:0], ge};
				den_s[k] <= den_p;
			end
		end
	end

	assign quot = low_s[QW-1];

endmodule

>>> src/radial_growth_force.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_growth_force: radial growth term added to a vertex derivative
// Adds rate*pos/|pos| (or rate*pos in linear mode) to the accumulated
// derivative, saturating to the signed fixed point range.
// ----------------------------------------------------------------------------
// Usage:
// Input beats (position, accumulated derivative, boundary flag) enter on
// in_valid/in_ready; each produces exactly one output beat on
// out_valid/out_ready, in order. Configuration is written through
// cfg_we/cfg_index/cfg_data while no beat is in flight.
// From accept to out_valid a beat passes three input stages, a square
// root of VALUE_WIDTH+1 stages, a divider of VALUE_WIDTH stages and the
// output register. Throughput is one beat per cycle while the output
// buffer is not full, set by the fully pipelined root and divider units.
// A two-entry output buffer decouples the sides: when the receiver
// stalls the pipeline keeps accepting until the buffer fills, then
// holds every stage in place with nothing lost or repeated.
// Reset clears all valid bits and loads the register defaults (rate 0,
// unit direction mode, all vertices, three dimensions).
// ----------------------------------------------------------------------------
module radial_growth_force
	import rgf_pkg::*;
#(
	parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [VALUE_WIDTH-1:0] cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [VALUE_WIDTH-1:0] pos_x,
	input  logic [VALUE_WIDTH-1:0] pos_y,
	input  logic [VALUE_WIDTH-1:0] pos_z,
	input  logic [VALUE_WIDTH-1:0] acc_x,
	input  logic [VALUE_WIDTH-1:0] acc_y,
	input  logic [VALUE_WIDTH-1:0] acc_z,
	input  logic                   on_boundary,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VALUE_WIDTH-1:0] new_x,
	output logic [VALUE_WIDTH-1:0] new_y,
	output logic [VALUE_WIDTH-1:0] new_z,
	output logic                   saturated
);

	localparam int W      = VALUE_WIDTH;
	localparam int F      = FRACTION_BITS;
	localparam int RW     = W + 1;
	localparam int SSW    = 2 * W + 2;
	localparam int TW     = (2 * W - F > W) ? (2 * W - F) : W;
	localparam int SW     = TW + 2;
	localparam int SIDE_W = 3 * W + 6 + 3 * TW;
	localparam int VD     = RW + W;
	localparam int RES_W  = 3 * W + 1;
	localparam logic signed [SW-1:0] MAX_S = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [SW-1:0] MIN_S = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

	// Configuration registers.
	logic [W-1:0] growth_rate_q;
	logic         linear_mode_q;
	logic         boundary_only_q;
	logic [1:0]   active_dims_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			growth_rate_q   <= '0;
			linear_mode_q   <= 1'b0;
			boundary_only_q <= 1'b0;
			active_dims_q   <= 2'd3;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GROWTH_RATE:   growth_rate_q   <= cfg_data;
				REG_LINEAR_MODE:   linear_mode_q   <= cfg_data[0];
				REG_BOUNDARY_ONLY: boundary_only_q <= cfg_data[0];
				REG_ACTIVE_DIMS:   active_dims_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Pipeline advance: every stage moves unless the output buffer is full.
	logic en;
	logic skid_valid_q;

	assign en       = !skid_valid_q;
	assign in_ready = en;

	// Derived configuration values.
	logic [1:0]   dims_eff;
	logic         rneg;
	logic [W-1:0] rmag;
	logic         apply;
	logic [W-1:0] pos_in [3];
	logic [W-1:0] acc_in [3];

	always_comb begin
		dims_eff  = (active_dims_q == 2'd0) ? 2'd1 : active_dims_q;
		rneg      = growth_rate_q[W-1];
		rmag      = rneg ? (~growth_rate_q + 1'b1) : growth_rate_q;
		apply     = !boundary_only_q || on_boundary;
		pos_in[0] = pos_x;
		pos_in[1] = pos_y;
		pos_in[2] = pos_z;
		acc_in[0] = acc_x;
		acc_in[1] = acc_y;
		acc_in[2] = acc_z;
	end

	// Stage 1: magnitudes, term signs and per coordinate enables.
	logic         v_s1;
	logic [W-1:0] pmag_s1 [3];
	logic [W-1:0] acc_s1  [3];
	logic [2:0]   sgn_s1;
	logic [2:0]   act_s1;
	logic [2:0]   use_s1;
	logic [W-1:0] rmag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rmag_s1 <= rmag;
			for (int d = 0; d < 3; d++) begin
				pmag_s1[d] <= pos_in[d][W-1] ? (~pos_in[d] + 1'b1) : pos_in[d];
				acc_s1[d]  <= acc_in[d];
				sgn_s1[d]  <= rneg ^ pos_in[d][W-1];
				use_s1[d]  <= (2'(d) < dims_eff);
				act_s1[d]  <= apply && (2'(d) < dims_eff);
			end
		end
	end

	// Stage 2: squares of the active coordinates and rate products.
	logic           v_s2;
	logic [2*W-1:0] sq_s2  [3];
	logic [2*W-1:0] num_s2 [3];
	logic [W-1:0]   acc_s2 [3];
	logic [2:0]     sgn_s2;
	logic [2:0]     act_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s2 <= sgn_s1;
			act_s2 <= act_s1;
			for (int d = 0; d < 3; d++) begin
				sq_s2[d]  <= use_s1[d] ? (pmag_s1[d] * pmag_s1[d]) : '0;
				num_s2[d] <= rmag_s1 * pmag_s1[d];
				acc_s2[d] <= acc_s1[d];
			end
		end
	end

	// Stage 3: sum of squares and the linear mode terms.
	logic           v_s3;
	logic [SSW-1:0] ss_s3;
	logic [2*W-1:0] num_s3 [3];
	logic [TW-1:0]  lin_s3 [3];
	logic [W-1:0]   acc_s3 [3];
	logic [2:0]     sgn_s3;
	logic [2:0]     act_s3;
	logic [2*W-1:0] num_sh [3];

	always_comb begin
		for (int d = 0; d < 3; d++) begin
			num_sh[d] = num_s2[d] >> F;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s3  <= SSW'(sq_s2[0]) + SSW'(sq_s2[1]) + SSW'(sq_s2[2]);
			sgn_s3 <= sgn_s2;
			act_s3 <= act_s2;
			for (int d = 0; d < 3; d++) begin
				num_s3[d] <= num_s2[d];
				lin_s3[d] <= num_sh[d][TW-1:0];
				acc_s3[d] <= acc_s2[d];
			end
		end
	end

	// Vector length.
	logic [RW-1:0] root;

	rgf_isqrt #(
		.IN_W(SSW)
	) u_isqrt (
		.clk      (clk),
		.en       (en),
		.radicand (ss_s3),
		.root     (root)
	);

	// Numerators wait for the root.
	logic [6*W-1:0] num_pk;
	logic [6*W-1:0] num_dly;

	assign num_pk = {num_s3[2], num_s3[1], num_s3[0]};

	rgf_delay #(
		.WIDTH (6 * W),
		.DEPTH (RW)
	) u_num_dly (
		.clk  (clk),
		.en   (en),
		.din  (num_pk),
		.dout (num_dly)
	);

	// One divider per coordinate.
	logic [W-1:0] quot [3];

	for (genvar d = 0; d < 3; d++) begin : g_div
		rgf_div #(
			.QW(W)
		) u_div (
			.clk  (clk),
			.en   (en),
			.num  (num_dly[d*2*W +: 2*W]),
			.den  (root),
			.quot (quot[d])
		);
	end

	// Zero length flag follows the divider.
	logic rz_dly;

	rgf_delay #(
		.WIDTH (1),
		.DEPTH (W)
	) u_rz_dly (
		.clk  (clk),
		.en   (en),
		.din  (root == '0),
		.dout (rz_dly)
	);

	// Valid bits travel past the root and divider in a cleared shift register.
	logic [VD-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[VD-2:0], v_s3};
		end
	end

	// Side data travel alongside the valid bits.
	logic [SIDE_W-1:0] side_pk;
	logic [SIDE_W-1:0] side_dly;

	assign side_pk = {acc_s3[2], acc_s3[1], acc_s3[0], sgn_s3, act_s3,
		lin_s3[2], lin_s3[1], lin_s3[0]};

	rgf_delay #(
		.WIDTH (SIDE_W),
		.DEPTH (VD)
	) u_side_dly (
		.clk  (clk),
		.en   (en),
		.din  (side_pk),
		.dout (side_dly)
	);

	// Final add and saturation.
	logic                 fin_valid;
	logic [2:0]           fin_act;
	logic [2:0]           fin_sgn;
	logic [TW-1:0]        term;
	logic signed [SW-1:0] accs;
	logic signed [SW-1:0] tms;
	logic signed [SW-1:0] sum;
	logic [W-1:0]         res_v [3];
	logic                 res_sat;
	logic [RES_W-1:0]     res_pk;

	always_comb begin
		fin_valid = vld_q[VD-1];
		fin_sgn   = side_dly[3*TW+3 +: 3];
		fin_act   = side_dly[3*TW +: 3];
		res_sat   = 1'b0;
		term      = '0;
		accs      = '0;
		tms       = '0;
		sum       = '0;
		for (int d = 0; d < 3; d++) begin
			if (linear_mode_q) begin
				term = side_dly[d*TW +: TW];
			end else if (rz_dly) begin
				term = '0;
			end else begin
				term = TW'(quot[d]);
			end
			accs = SW'(signed'(side_dly[3*TW+6+d*W +: W]));
			tms  = signed'(SW'(term));
			if (!fin_act[d]) begin
				sum = accs;
			end else if (fin_sgn[d]) begin
				sum = accs - tms;
			end else begin
				sum = accs + tms;
			end
			if (sum > MAX_S) begin
				sum     = MAX_S;
				res_sat = 1'b1;
			end else if (sum < MIN_S) begin
				sum     = MIN_S;
				res_sat = 1'b1;
			end
			res_v[d] = sum[W-1:0];
		end
		res_pk = {res_sat, res_v[2], res_v[1], res_v[0]};
	end

	// Output register with one skid entry behind it.
	logic             out_valid_q;
	logic [RES_W-1:0] out_q;
	logic [RES_W-1:0] skid_q;
	logic             push;
	logic             pop;

	assign push = fin_valid && en;
	assign pop  = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || pop) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || pop) begin
			out_q <= res_pk;
		end else begin
			skid_q <= res_pk;
		end
	end

	assign out_valid = out_valid_q;
	assign new_x     = out_q[W-1:0];
	assign new_y     = out_q[2*W-1:W];
	assign new_z     = out_q[3*W-1:2*W];
	assign saturated = out_q[RES_W-1];

endmodule

>>> verif/tb_radial_growth_force.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radial_growth_force: self-checking bench for the radial growth pipeline
// Drives vertex beats through a directed table and then random traffic, with
// random gaps and receiver stalls, across several register settings. Every
// output beat is compared with a local model of the growth term.
// ----------------------------------------------------------------------------
module tb_radial_growth_force;
	import rgf_pkg::*;

	localparam int W    = 32;
	localparam int FB   = 16;
	localparam int LAT  = 2 * W + 5;
	localparam int WDOG = 20000;
	localparam logic [W-1:0] VMAX = 32'h7fff_ffff;
	localparam logic [W-1:0] VMIN = 32'h8000_0000;

	typedef struct packed {
		logic [W-1:0] px, py, pz, ax, ay, az;
		logic         bnd;
	} vertex_t;

	typedef struct packed {
		logic [W-1:0] nx, ny, nz;
		logic         sat;
	} deriv_t;

	// Directed row: vertex, whether a typed result applies, and that result.
	typedef struct {
		vertex_t v;
		bit      typed;
		deriv_t  r;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [W-1:0] acc_x = '0, acc_y = '0, acc_z = '0;
	logic on_boundary = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [W-1:0] new_x, new_y, new_z;
	logic saturated;

	// Shadow copy of the configuration registers.
	logic [W-1:0] rate_q;
	logic         linear_q, bonly_q;
	logic [1:0]   dims_q;

	deriv_t expected_derivs[$];
	deriv_t typed_q[$];
	bit     typed_flag[$];
	int     errors = 0;
	int     idle_cycles = 0;
	int     stall_left = 0;
	bit     stall_enable = 1;

	radial_growth_force u_top (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog: counts cycles with no accepted beat on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WDOG) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic longint unsigned mag(logic [W-1:0] v);
		return v[W-1] ? longint'(-$signed({1'b0, ~v}) - 1) * -1 : longint'(v);
	endfunction

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Growth term added to the derivative, saturating each component.
	function automatic deriv_t grow_derivative(vertex_t v);
		deriv_t o;
		logic [W-1:0] p[3], a[3], n[3];
		longint unsigned pm[3], rm, ss, r, num, tm;
		longint sum;
		int dims;
		bit apply;
		p = '{v.px, v.py, v.pz};
		a = '{v.ax, v.ay, v.az};
		dims = (dims_q == 0) ? 1 : int'(dims_q);
		apply = !bonly_q || v.bnd;
		rm = mag(rate_q);
		o.sat = 0;
		ss = 0;
		for (int d = 0; d < 3; d++)
			pm[d] = mag(p[d]);
		for (int d = 0; d < dims; d++)
			ss += pm[d] * pm[d];
		r = root64(ss);
		for (int d = 0; d < 3; d++) begin
			sum = longint'($signed(a[d]));
			if (apply && d < dims) begin
				num = rm * pm[d];
				if (linear_q)
					tm = num >> FB;
				else
					tm = (r != 0) ? num / r : 0;
				sum += (rate_q[W-1] != p[d][W-1]) ? -longint'(tm) : longint'(tm);
			end
			if (sum > 64'sh7fff_ffff) begin
				sum = 64'sh7fff_ffff;
				o.sat = 1;
			end else if (sum < -64'sh8000_0000) begin
				sum = -64'sh8000_0000;
				o.sat = 1;
			end
			n[d] = sum[W-1:0];
		end
		o.nx = n[0];
		o.ny = n[1];
		o.nz = n[2];
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Output side: random stalls, mostly short and a few long, and comparison.
	always @(posedge clk) begin
		deriv_t e;
		if (out_valid && out_ready) begin
			if (expected_derivs.size() == 0) begin
				report_mismatch("unexpected beat", new_x, '0);
			end else begin
				e = expected_derivs.pop_front();
				if (typed_flag.pop_front()) begin
					if (typed_q.pop_front() != e)
						report_mismatch("table row", '0, '1);
				end
				if (new_x !== e.nx) report_mismatch("new_x", new_x, e.nx);
				if (new_y !== e.ny) report_mismatch("new_y", new_y, e.ny);
				if (new_z !== e.nz) report_mismatch("new_z", new_z, e.nz);
				if (saturated !== e.sat)
					report_mismatch("saturated", W'(saturated), W'(e.sat));
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (stall_enable && $urandom_range(0, 3) == 0) begin
			stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(5, 60)
				: $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_GROWTH_RATE:   rate_q = val;
			REG_LINEAR_MODE:   linear_q = val[0];
			REG_BOUNDARY_ONLY: bonly_q = val[0];
			default:           dims_q = val[1:0];
		endcase
	endtask

	task automatic set_config(logic [W-1:0] rate, bit lin, bit bo, logic [1:0] dims);
		while (expected_derivs.size() != 0)
			@(posedge clk);
		repeat (LAT + 4) @(posedge clk);
		write_reg(REG_GROWTH_RATE, rate);
		write_reg(REG_LINEAR_MODE, W'(lin));
		write_reg(REG_BOUNDARY_ONLY, W'(bo));
		write_reg(REG_ACTIVE_DIMS, W'(dims));
		cfg_we <= 1'b0;
	endtask

	// Sends one beat, with an optional idle gap before it.
	task automatic send_vertex(vertex_t v, bit typed, deriv_t r, bit gaps);
		int gap;
		if (gaps) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
			if ($urandom_range(0, 2) == 0)
				gap = 0;
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		{pos_x, pos_y, pos_z, acc_x, acc_y, acc_z, on_boundary} <= v;
		expected_derivs.push_back(grow_derivative(v));
		typed_flag.push_back(typed);
		if (typed)
			typed_q.push_back(r);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	function automatic logic [W-1:0] rand_value();
		case ($urandom_range(0, 5))
			0: return VMAX;
			1: return VMIN;
			2: return W'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
			3: return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic vertex_t rand_vertex();
		vertex_t v;
		v.px = rand_value();
		v.py = rand_value();
		v.pz = rand_value();
		v.ax = rand_value();
		v.ay = rand_value();
		v.az = rand_value();
		v.bnd = 1'($urandom_range(0, 1));
		return v;
	endfunction

	task automatic finish_phase();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		row_t rows[$];
		deriv_t none;
		logic [W-1:0] rates[6];
		none = '0;
		rate_q = '0;
		linear_q = 0;
		bonly_q = 0;
		dims_q = 2'd3;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset the rate is zero, so acc passes through unchanged.
		rows.push_back('{'{VMAX, VMIN, 32'h1, 32'h1234_5678, VMIN, VMAX, 1'b0},
			1, '{32'h1234_5678, VMIN, VMAX, 1'b0}});
		rows.push_back('{'{'0, '0, '0, '0, '0, '0, 1'b1}, 1, '{'0, '0, '0, 1'b0}});
		foreach (rows[i])
			send_vertex(rows[i].v, rows[i].typed, rows[i].r, 0);
		finish_phase();

		// Unit direction at rate one: zero length adds nothing, axis adds rate.
		set_config(32'h0001_0000, 0, 0, 2'd3);
		rows.delete();
		rows.push_back('{'{'0, '0, '0, 32'h5, 32'h6, 32'h7, 1'b0}, 1, '{32'h5, 32'h6, 32'h7, 1'b0}});
		rows.push_back('{'{32'h0003_0000, '0, '0, '0, '0, '0, 1'b0},
			1, '{32'h0001_0000, '0, '0, 1'b0}});
		rows.push_back('{'{32'h0003_0000, '0, '0, VMAX, '0, '0, 1'b0},
			1, '{VMAX, '0, '0, 1'b1}});
		rows.push_back('{'{VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, 1'b1}, 0, none});
		rows.push_back('{'{VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, 1'b0}, 0, none});
		foreach (rows[i])
			send_vertex(rows[i].v, rows[i].typed, rows[i].r, 0);
		finish_phase();

		// Linear and unit direction modes, extreme rates, boundary gating and reduced dimensions.
		set_config(VMIN, 1, 1, 2'd1);
		send_vertex('{VMIN, VMAX, 32'h1, '0, '0, '0, 1'b0}, 1, '{'0, '0, '0, 1'b0}, 0);
		send_vertex('{VMIN, VMAX, 32'h1, VMIN, '0, '0, 1'b1}, 0, none, 0);
		send_vertex('{VMAX, VMAX, 32'h1, VMAX, 32'h9, '0, 1'b1}, 0, none, 0);
		finish_phase();
		set_config(VMAX, 0, 0, 2'd0);
		send_vertex('{VMAX, VMIN, VMIN, '0, 32'h3, 32'h4, 1'b0}, 0, none, 0);
		send_vertex('{'0, 32'h0001_0000, '0, 32'h2, 32'h3, 32'h4, 1'b0},
			1, '{32'h2, 32'h3, 32'h4, 1'b0}, 0);
		finish_phase();
		set_config(32'hffff_0000, 1, 0, 2'd2);
		send_vertex('{32'h0002_0000, VMIN, VMAX, '0, '0, 32'h8, 1'b0},
			1, '{32'hfffe_0000, VMAX, 32'h8, 1'b1}, 0);
		finish_phase();

		// Random traffic over several register settings.
		rates = '{VMAX, VMIN, 32'h0001_0000, 32'hfffe_8000, 32'h0000_0001, 32'h0};
		for (int ph = 0; ph < 11; ph++) begin
			stall_enable = (ph % 4 != 3);
			set_config((ph < 6) ? rates[ph] : W'($urandom), 1'($urandom_range(0, 1)),
				(ph % 3 == 0), 2'($urandom_range(0, 3)));
			for (int k = 0; k < 100; k++)
				send_vertex(rand_vertex(), 0, none, ph % 4 != 2);
			finish_phase();
		end

		while (expected_derivs.size() != 0)
			@(posedge clk);
		repeat (LAT + 10) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
